/* hdl/assert_macros.svh */
// Assertion helper macros used by the checker file of this block.
// Standalone header; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property that is checked on every rising clock edge while rst is low.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("port-level assertion failed");

// Same-cycle implication built on the macro above.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   `ASSERT_PROP(lbl, clk, rst, (ante) |-> (cons))

`endif

/* hdl/mib3_pkg.sv */
// Shared types and constants for the 3x3 mask inner-boundary block.
// No dependencies; used by the top level and the result queue.
`timescale 1ns / 1ps
`default_nettype none

package mib3_pkg;

   localparam int MAX_COLS_DEFAULT = 4096;
   localparam int MAX_ROWS_DEFAULT = 4096;

   localparam int CFG_W    = 13;   // width of a size register
   localparam int OUT_W    = 12;   // width of the reported position fields
   localparam int CSR_IDX_W = 1;

   localparam int RST_COLS = 640;
   localparam int RST_ROWS = 480;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_COLUMNS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS    = 1'd1;

   typedef struct packed {
      logic [OUT_W-1:0] out_row;
      logic [OUT_W-1:0] out_col;
      logic             is_boundary;
      logic             last_of_run;
   } rsp_type;

   // Up to two results enter the queue per cycle, first before second.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

`default_nettype wire

/* hdl/mib3_rsp_queue.sv */
// Two-entry result queue that lets one item push two results in one cycle.
// Depends on mib3_pkg for the result and push types.
`timescale 1ns / 1ps
`default_nettype none

module mib3_rsp_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mib3_pkg::push_type push,
   input  wire logic               pop,
   output      logic               head_valid,
   output      mib3_pkg::rsp_type  head,
   output      logic [1:0]         level
);

   mib3_pkg::rsp_type entry_ff [2];
   mib3_pkg::rsp_type entry_in [2];
   logic [1:0]        level_ff;
   logic [1:0]        level_in;

   // The producer only pushes what fits after this cycle's pop.
   always_comb begin
      logic [1:0] lvl;
      entry_in[0] = entry_ff[0];
      entry_in[1] = entry_ff[1];
      lvl         = level_ff;
      if (pop) begin
         entry_in[0] = entry_ff[1];
         lvl         = lvl - 2'd1;
      end
      if (push.count != 2'd0) begin
         entry_in[lvl[0]] = push.first;
      end
      if (push.count == 2'd2) begin
         entry_in[1] = push.second;
      end
      level_in = lvl + push.count;
   end

   always_ff @(posedge clock) begin
      entry_ff[0] <= entry_in[0];
      entry_ff[1] <= entry_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 2'd0;
      end else begin
         level_ff <= level_in;
      end
   end

   assign head_valid = (level_ff != 2'd0);
   assign head       = entry_ff[0];
   assign level      = level_ff;

endmodule

`default_nettype wire

/* hdl/mask_inner_boundary_3x3.sv */
// Top level of the streaming 3x3 inner-boundary detector for binary masks.
// Depends on mib3_pkg and instantiates mib3_rsp_queue.
`timescale 1ns / 1ps
`default_nettype none

//  Channel  Direction  Handshake             Payload
//  req      in         req_valid/req_ready   req_mask_bit
//  rsp      out        rsp_valid/rsp_ready   rsp_out_row, rsp_out_col, rsp_is_boundary,
//                                            rsp_last_of_run
//  csr      in         csr_valid/csr_ready   csr_index, csr_wdata
//
//  One pixel transfer can be taken every cycle. A pixel's results pass through the stage-1
//  registers, with the line-store read register, and then the result queue to reach rsp.
//  A pixel that yields two results needs two transfers on rsp; the two-entry
//  queue absorbs that, and req_ready drops only when the queue cannot take them.
//  Reset is synchronous and active high; afterwards the frame starts at row 0, column 0
//  with the sizes 640 x 480 (clamped to the parameters). csr_ready is always high.

module mask_inner_boundary_3x3 #(
   parameter int MAX_COLS = mib3_pkg::MAX_COLS_DEFAULT,
   parameter int MAX_ROWS = mib3_pkg::MAX_ROWS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,

   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic                           req_mask_bit,

   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic [mib3_pkg::OUT_W-1:0]     rsp_out_row,
   output      logic [mib3_pkg::OUT_W-1:0]     rsp_out_col,
   output      logic                           rsp_is_boundary,
   output      logic                           rsp_last_of_run,

   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [mib3_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [mib3_pkg::CFG_W-1:0]     csr_wdata
);

   localparam int CIDX_W = $clog2(MAX_COLS);
   localparam int RIDX_W = $clog2(MAX_ROWS);

   // Reset sizes, clamped to what the line stores and counters can hold.
   localparam int RST_COLS_LAST =
      ((mib3_pkg::RST_COLS > MAX_COLS) ? MAX_COLS : mib3_pkg::RST_COLS) - 1;
   localparam int RST_ROWS_LAST =
      ((mib3_pkg::RST_ROWS > MAX_ROWS) ? MAX_ROWS : mib3_pkg::RST_ROWS) - 1;

   // Frame geometry, held as the index of the last column and last row.
   logic [CIDX_W-1:0] cols_last_ff, cols_last_in;
   logic [RIDX_W-1:0] rows_last_ff, rows_last_in;

   // Raster position of the next pixel to arrive.
   logic [CIDX_W-1:0] col_ff, col_in;
   logic [RIDX_W-1:0] row_ff, row_in;

   // Stage 1: the accepted pixel, its position and the line-store read data.
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_bit_ff;
   logic [CIDX_W-1:0] s1_col_ff;
   logic [RIDX_W-1:0] s1_row_ff;
   logic              s1_inner_ff;
   logic              s1_edge_ff;
   logic [1:0]        rd_ff;

   // 3x3 window; bit 3*k+j is window row k (0 = top) and column j (0 = left).
   logic [8:0]        window_ff, window_in;

   // Each line-store entry holds {upper row, middle row} for one column.
   logic [1:0]        line_mem [MAX_COLS];

   logic              req_xfer;
   logic              csr_xfer;
   logic              rsp_xfer;
   logic              s1_move;
   logic [1:0]        s1_count;
   logic [1:0]        q_level;
   logic              at_col_last;
   logic              at_row_last;
   logic              next_inner;
   logic              next_edge;
   logic              centre;
   logic [31:0]       wdata_ext;
   logic [31:0]       cols_tmp;
   logic [31:0]       rows_tmp;
   logic [31:0]       irow_ext, icol_ext, erow_ext, ecol_ext;

   mib3_pkg::push_type push;
   mib3_pkg::rsp_type  inner_rsp;
   mib3_pkg::rsp_type  edge_rsp;
   mib3_pkg::rsp_type  head;

   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;

   // ---------------------------------------------------------------------------------------
   // Configuration: a zero size acts as one, an oversize value as the parameter limit.
   // Any write restarts the frame; the line stores keep their contents.
   // ---------------------------------------------------------------------------------------
   assign wdata_ext = 32'(csr_wdata);

   always_comb begin
      cols_last_in = cols_last_ff;
      rows_last_in = rows_last_ff;
      if (wdata_ext == 32'd0) begin
         cols_tmp = 32'd0;
         rows_tmp = 32'd0;
      end else begin
         cols_tmp = (wdata_ext > 32'(MAX_COLS)) ? 32'(MAX_COLS - 1) : wdata_ext - 32'd1;
         rows_tmp = (wdata_ext > 32'(MAX_ROWS)) ? 32'(MAX_ROWS - 1) : wdata_ext - 32'd1;
      end
      if (csr_xfer) begin
         unique case (csr_index)
            mib3_pkg::CSR_IMAGE_COLUMNS: cols_last_in = cols_tmp[CIDX_W-1:0];
            mib3_pkg::CSR_IMAGE_ROWS:    rows_last_in = rows_tmp[RIDX_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_last_ff <= CIDX_W'(RST_COLS_LAST);
         rows_last_ff <= RIDX_W'(RST_ROWS_LAST);
      end else begin
         cols_last_ff <= cols_last_in;
         rows_last_ff <= rows_last_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Position counters and the edge / interior classification of the arriving pixel.
   // ---------------------------------------------------------------------------------------
   assign at_col_last = (col_ff == cols_last_ff);
   assign at_row_last = (row_ff == rows_last_ff);
   assign next_inner  = (row_ff >= RIDX_W'(2)) && (col_ff >= CIDX_W'(2));
   assign next_edge   = (row_ff == '0) || at_row_last || (col_ff == '0) || at_col_last;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_xfer) begin
         col_in = '0;
         row_in = '0;
      end else if (req_xfer) begin
         if (at_col_last) begin
            col_in = '0;
            row_in = at_row_last ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 1 holds one pixel. It leaves when the result queue, after this cycle's rsp
   // transfer, has room for every result that the pixel yields (zero, one or two).
   // ---------------------------------------------------------------------------------------
   assign s1_count = {1'b0, s1_inner_ff} + {1'b0, s1_edge_ff};
   assign s1_move  = s1_valid_ff &&
                     ((3'(q_level) - 3'(rsp_xfer) + 3'(s1_count)) <= 3'd2);
   assign req_ready = !s1_valid_ff || s1_move;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_bit_ff   <= req_mask_bit;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_inner_ff <= next_inner;
         s1_edge_ff  <= next_edge;
      end
   end

   // Line stores: the column's entry is read as the pixel arrives and rewritten, shifted
   // down by one row, as it leaves stage 1. The same column comes back only a full row
   // later, so the write always lands before the next read of that entry whenever the
   // stored rows can reach a result (three or more columns).
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rd_ff <= line_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         line_mem[s1_col_ff] <= {rd_ff[0], s1_bit_ff};
      end
   end

   // Window shifts left by one column per pixel; the new right column is
   // {upper store, middle store, arriving pixel} from top to bottom.
   always_comb begin
      window_in = window_ff;
      if (csr_xfer) begin
         window_in = '0;
      end else if (s1_move) begin
         window_in = {s1_bit_ff, window_ff[8:7], rd_ff[0], window_ff[5:4],
                      rd_ff[1], window_ff[2:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Results. The interior result describes the pixel up and left of the arriving one and
   // always goes first; the edge result describes the arriving pixel itself.
   // ---------------------------------------------------------------------------------------
   assign centre   = window_in[4];
   assign irow_ext = 32'(RIDX_W'(s1_row_ff - 1'b1));
   assign icol_ext = 32'(CIDX_W'(s1_col_ff - 1'b1));
   assign erow_ext = 32'(s1_row_ff);
   assign ecol_ext = 32'(s1_col_ff);

   always_comb begin
      inner_rsp.out_row     = irow_ext[mib3_pkg::OUT_W-1:0];
      inner_rsp.out_col     = icol_ext[mib3_pkg::OUT_W-1:0];
      inner_rsp.is_boundary = centre && (window_in != 9'h1FF);
      inner_rsp.last_of_run = !s1_edge_ff;

      edge_rsp.out_row      = erow_ext[mib3_pkg::OUT_W-1:0];
      edge_rsp.out_col      = ecol_ext[mib3_pkg::OUT_W-1:0];
      edge_rsp.is_boundary  = s1_bit_ff;
      edge_rsp.last_of_run  = 1'b1;

      push.count  = s1_move ? s1_count : 2'd0;
      push.first  = s1_inner_ff ? inner_rsp : edge_rsp;
      push.second = edge_rsp;
   end

   mib3_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_xfer),
      .head_valid (rsp_valid),
      .head       (head),
      .level      (q_level)
   );

   assign rsp_out_row     = head.out_row;
   assign rsp_out_col     = head.out_col;
   assign rsp_is_boundary = head.is_boundary;
   assign rsp_last_of_run = head.last_of_run;

endmodule

`default_nettype wire

/* hdl/mib3_checker.sv */
// Port-level checker for the 3x3 mask inner-boundary block, bound to its top level.
// Depends on assert_macros.svh and mib3_pkg.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mib3_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [mib3_pkg::OUT_W-1:0]     rsp_out_row,
   input wire logic [mib3_pkg::OUT_W-1:0]     rsp_out_col,
   input wire logic                           rsp_is_boundary,
   input wire logic                           rsp_last_of_run
);

   logic                           rsp_xfer;
   logic                           rsp_stall;
   logic                           pair_next;
   logic [2*mib3_pkg::OUT_W+1:0]   rsp_payload;
   logic                           pend_ff;
   logic [mib3_pkg::OUT_W-1:0]     prev_row_ff;
   logic [mib3_pkg::OUT_W-1:0]     prev_col_ff;

   assign rsp_xfer    = rsp_valid && rsp_ready;
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_out_row, rsp_out_col, rsp_is_boundary, rsp_last_of_run};
   assign pair_next   = rsp_last_of_run &&
                        (rsp_out_row == prev_row_ff + mib3_pkg::OUT_W'(1)) &&
                        (rsp_out_col == prev_col_ff + mib3_pkg::OUT_W'(1));

   // Remember whether the last transferred result left its item unfinished.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (rsp_xfer) begin
         pend_ff <= !rsp_last_of_run;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_xfer) begin
         prev_row_ff <= rsp_out_row;
         prev_col_ff <= rsp_out_col;
      end
   end

   // Reset leaves no result pending and the pixel input open.
   `ASSERT_PROP(a_reset_clears, clock, 1'b0, reset |=> !rsp_valid && req_ready)

   // A stalled result holds its payload.
   `ASSERT_PROP(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_payload))

   // An interior result that is not last is followed by the edge result of the pixel
   // one row down and one column right, which closes the item.
   `ASSERT_IMPLY(a_pair_order, clock, reset, rsp_xfer && pend_ff, pair_next)

endmodule

bind mask_inner_boundary_3x3 mib3_checker u_mib3_checker (.*);

`default_nettype wire

/* tb/mib3_scoreboard_pkg.sv */
// Scoreboard for the 3x3 mask inner-boundary block: it predicts the results of each pixel
// and checks them in order. Depends on mib3_pkg for the result type, widths and CSR indexes.
`timescale 1ns / 1ps

package mib3_scoreboard_pkg;
   import mib3_pkg::*;

   localparam int unsigned LINE_DEPTH = MAX_COLS_DEFAULT;
   localparam int unsigned FRAME_ROWS_LIMIT = MAX_ROWS_DEFAULT;
   localparam int unsigned REPORT_LIMIT = 10;

   class boundary_scoreboard;
      bit upper_line[LINE_DEPTH];
      bit middle_line[LINE_DEPTH];
      bit [8:0] window;
      int unsigned row_pos;
      int unsigned col_pos;
      bit [CFG_W-1:0] columns_reg;
      bit [CFG_W-1:0] rows_reg;
      rsp_type results_due[$];
      int unsigned mismatches;

      function new();
         window = '0;
         row_pos = 0;
         col_pos = 0;
         columns_reg = CFG_W'(RST_COLS);
         rows_reg = CFG_W'(RST_ROWS);
         mismatches = 0;
      endfunction

      function int unsigned pending();
         return results_due.size();
      endfunction

      // A size of zero behaves as one, and anything above the given limit is clamped to it.
      static function int unsigned active_size(bit [CFG_W-1:0] value, int unsigned limit);
         if (value == 0) return 1;
         if (value > limit) return limit;
         return value;
      endfunction

      function void note_config(logic [CSR_IDX_W-1:0] index, bit [CFG_W-1:0] value);
         case (index)
            CSR_IMAGE_COLUMNS: columns_reg = value;
            CSR_IMAGE_ROWS:    rows_reg = value;
            default:           return;
         endcase
         // Any write restarts the frame; the line stores keep what they hold.
         row_pos = 0;
         col_pos = 0;
         window = '0;
      endfunction

      function void note_pixel(bit mask_bit);
         int unsigned cols;
         int unsigned rows;
         bit above2;
         bit above1;
         rsp_type found[2];
         int n;
         int i;
         cols = active_size(columns_reg, LINE_DEPTH);
         rows = active_size(rows_reg, FRAME_ROWS_LIMIT);
         above2 = upper_line[col_pos];
         above1 = middle_line[col_pos];
         upper_line[col_pos] = above1;
         middle_line[col_pos] = mask_bit;
         // Each window row shifts left by one column; the newest column enters at the top bit.
         window = {mask_bit, window[8:7], above1, window[5:4], above2, window[2:1]};
         n = 0;
         if (row_pos >= 2 && col_pos >= 2) begin
            found[n].out_row = OUT_W'(row_pos - 1);
            found[n].out_col = OUT_W'(col_pos - 1);
            found[n].is_boundary = window[4] && (window != 9'h1FF);
            found[n].last_of_run = 1'b0;
            n++;
         end
         if (row_pos == 0 || row_pos + 1 >= rows || col_pos == 0 || col_pos + 1 >= cols) begin
            found[n].out_row = OUT_W'(row_pos);
            found[n].out_col = OUT_W'(col_pos);
            found[n].is_boundary = mask_bit;
            found[n].last_of_run = 1'b0;
            n++;
         end
         for (i = 0; i < n; i++) begin
            found[i].last_of_run = (i == n - 1);
            results_due = {results_due, found[i]};
         end
         col_pos++;
         if (col_pos >= cols) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= rows) row_pos = 0;
         end
      endfunction

      function void check_result(logic [OUT_W-1:0] row, logic [OUT_W-1:0] col,
                                 logic boundary, logic last);
         rsp_type want;
         if (results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result: row %0d col %0d boundary %b last %b",
                        row, col, boundary, last);
            return;
         end
         want = results_due.pop_front();
         if (row !== want.out_row || col !== want.out_col ||
             boundary !== want.is_boundary || last !== want.last_of_run) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("result mismatch: expected %0d,%0d,%b,%b got %0d,%0d,%b,%b",
                        want.out_row, want.out_col, want.is_boundary, want.last_of_run,
                        row, col, boundary, last);
         end
      endfunction
   endclass

endpackage

/* tb/mask_inner_boundary_3x3_test.sv */
// Top-level testbench for mask_inner_boundary_3x3: drives pixel and CSR transfers and checks
// every result against the scoreboard. Depends on mib3_pkg and mib3_scoreboard_pkg.
`timescale 1ns / 1ps

module mask_inner_boundary_3x3_test;
   import mib3_pkg::*;
   import mib3_scoreboard_pkg::*;

   // Least number of pixels in the randomized part, before the fixed-size phases.
   localparam int unsigned RANDOM_ITEMS = 750;
   // The block reports a pixel through stage 1 and the result queue; this leaves a safe margin.
   localparam int unsigned SETTLE_CYCLES = 8;
   // Cycles without any transfer before the run is declared hung.
   localparam int unsigned STALL_LIMIT = 5000;
   // Length of the deliberate receiver hold-off that backs the block up.
   localparam int unsigned LONG_HOLD_CYCLES = 400;

   typedef enum int {WRITE_BOTH, WRITE_COLUMNS, WRITE_ROWS} size_write_kind;
   typedef enum int {ALWAYS_READY, COIN_FLIP, MOSTLY_STALLED, FIXED_PATTERN} ready_style;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   logic req_mask_bit = 1'b0;

   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [OUT_W-1:0] rsp_out_row;
   logic [OUT_W-1:0] rsp_out_col;
   logic rsp_is_boundary;
   logic rsp_last_of_run;

   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_IMAGE_COLUMNS;
   logic [CFG_W-1:0] csr_wdata = '0;

   boundary_scoreboard boundary_check = new();

   // Set by the stimulus to ask the receiver for one long hold-off.
   bit long_hold_request = 1'b0;
   // When clear, the sender offers pixels back to back with no gaps.
   bit gaps_on = 1'b1;
   int unsigned burst_left = 0;
   int unsigned idle_cycles = 0;

   mask_inner_boundary_3x3 u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mask_bit    (req_mask_bit),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_is_boundary (rsp_is_boundary),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // The watchdog restarts its count on any transfer on any channel. If the idle count
   // reaches STALL_LIMIT without a transfer, the run is over.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // The receiver samples the result channel at each rising edge, before anything changes,
   // and then chooses rsp_ready for the next cycle. It switches among several stall styles
   // at random intervals, and serves one long hold-off when the stimulus asks for it.
   initial begin : receiver
      ready_style style;
      int unsigned style_left;
      int unsigned hold_left;
      int unsigned tick;
      style = ALWAYS_READY;
      style_left = 0;
      hold_left = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            boundary_check.check_result(rsp_out_row, rsp_out_col, rsp_is_boundary,
                                        rsp_last_of_run);
         tick++;
         if (long_hold_request) begin
            hold_left = LONG_HOLD_CYCLES;
            long_hold_request = 1'b0;
         end
         if (style_left == 0) begin
            style = ready_style'($urandom_range(3));
            style_left = $urandom_range(20, 300);
         end
         style_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (style)
               ALWAYS_READY:   rsp_ready <= 1'b1;
               COIN_FLIP:      rsp_ready <= 1'($urandom_range(1));
               MOSTLY_STALLED: rsp_ready <= ($urandom_range(3) == 0);
               default:        rsp_ready <= (tick % 7 != 2) && (tick % 7 != 3);
            endcase
         end
      end
   end

   // Offers one pixel and returns at the edge where it is transferred. Pixels go out in
   // bursts; between bursts the sender drops valid for a random gap unless gaps are off.
   // Valid stays high from one pixel to the next inside a burst.
   task automatic send_pixel(bit value);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = gaps_on ? $urandom_range(1, 10) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_mask_bit <= value;
      do @(posedge clock); while (!req_ready);
      boundary_check.note_pixel(value);
   endtask

   // Random pixels, each set with the given probability in percent.
   task automatic send_random(int unsigned count, int unsigned percent_set);
      repeat (count) send_pixel($urandom_range(99) < percent_set);
   endtask

   // A fixed run of pixels, first pixel in bit 0.
   task automatic send_bits(bit [8:0] pattern, int unsigned count);
      int unsigned i;
      for (i = 0; i < count; i++) send_pixel(pattern[i]);
   endtask

   // Stops offering pixels and waits for every outstanding result. Pixels in the middle of
   // a row can produce nothing, so it also waits out SETTLE_CYCLES to let any in flight settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (boundary_check.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_valid high so that two writes can follow each other directly.
   task automatic csr_write(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      boundary_check.note_config(index, value);
   endtask

   // Sizes are only changed with the block idle.
   task automatic write_sizes(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows,
                              size_write_kind kind);
      drain();
      if (kind != WRITE_ROWS) csr_write(CSR_IMAGE_COLUMNS, cols);
      if (kind != WRITE_COLUMNS) csr_write(CSR_IMAGE_ROWS, rows);
      csr_valid <= 1'b0;
   endtask

   // Mostly small images so that frames wrap often and interior pixels are common;
   // the degenerate sizes zero, one and two show up regularly.
   function automatic logic [CFG_W-1:0] pick_size();
      case ($urandom_range(11))
         0:       return CFG_W'(0);
         1:       return CFG_W'(1);
         2:       return CFG_W'(2);
         3:       return CFG_W'(3);
         4:       return CFG_W'($urandom_range(15, 40));
         default: return CFG_W'($urandom_range(4, 14));
      endcase
   endfunction

   initial begin : stimulus
      int unsigned sent;
      int unsigned phase;
      int unsigned count;
      int unsigned percent_set;
      logic [CFG_W-1:0] cols;
      logic [CFG_W-1:0] rows;
      size_write_kind kind;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // A short run at the reset sizes; only first-row results appear.
      send_random(20, 60);

      // A 3x3 image, completely set: the center pixel is interior and reported as not
      // on the boundary, together with the last pixel of the frame.
      write_sizes(CFG_W'(3), CFG_W'(3), WRITE_BOTH);
      send_bits(9'h1FF, 9);
      // The next frame clears only the last corner, so the center becomes a boundary
      // pixel, and the clear corner itself is reported as not on the boundary.
      send_bits(9'h0FF, 9);

      // Zero sizes act as a one-pixel image: every pixel is its own frame.
      write_sizes(CFG_W'(0), CFG_W'(0), WRITE_BOTH);
      send_bits(9'b101, 3);

      // Randomized phases. Each phase picks new sizes (sometimes only one register),
      // a density of set pixels and whether the sender leaves gaps. The second phase
      // runs the sender flat out while the receiver holds off for a long stretch, so the
      // result queue fills and the block pushes back on its input.
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         cols = pick_size();
         rows = pick_size();
         kind = (phase == 0) ? WRITE_BOTH : size_write_kind'($urandom_range(2));
         write_sizes(cols, rows, kind);
         case ($urandom_range(3))
            0:       percent_set = 50;
            1:       percent_set = 80;
            2:       percent_set = 95;
            default: percent_set = 100;
         endcase
         gaps_on = ($urandom_range(3) != 0);
         if (phase == 1) begin
            gaps_on = 1'b0;
            long_hold_request = 1'b1;
         end
         count = $urandom_range(40, 160);
         send_random(count, percent_set);
         sent += count;
         phase++;
      end
      gaps_on = 1'b1;

      // Oversized column count clamps to the full store; with a single row every pixel
      // is reported as an edge pixel of that row.
      write_sizes(CFG_W'(13'h1FFF), CFG_W'(1), WRITE_BOTH);
      send_random(20, 70);

      // Oversized row count with one column: every pixel starts a new row.
      write_sizes(CFG_W'(1), CFG_W'(13'h1FFF), WRITE_BOTH);
      send_random(20, 70);

      // The largest legal sizes, briefly.
      write_sizes(CFG_W'(MAX_COLS_DEFAULT), CFG_W'(MAX_ROWS_DEFAULT), WRITE_BOTH);
      send_random(20, 90);

      // A wider image with several rows, so the rows fill far line-store entries before interior results appear.
      write_sizes(CFG_W'(150), CFG_W'(4), WRITE_BOTH);
      send_random(330, 95);

      drain();
      if (boundary_check.mismatches == 0 && boundary_check.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/mib3_pkg.sv
hdl/mib3_rsp_queue.sv
hdl/mask_inner_boundary_3x3.sv
hdl/mib3_checker.sv
tb/mib3_scoreboard_pkg.sv
tb/mask_inner_boundary_3x3_test.sv
